// ===== hdl/vsd_pkg.sv =====
// Shared types and constants for the variance settle detector.
`timescale 1ns / 1ps
`default_nettype none

package vsd_pkg;

  localparam int WINDOW_DEF = 10;
  localparam int DATA_W     = 32;
  localparam int AXES       = 3;

  // 1000.0 and 0.001 in unsigned Q12.20
  localparam logic [DATA_W-1:0] INIT_LEVEL   = 32'd1048576000;
  localparam logic [DATA_W-1:0] THRESH_RESET = 32'd1049;

  typedef logic [AXES-1:0][DATA_W-1:0] sample3_t;

  typedef struct packed {
    logic [DATA_W-1:0] variance_x;
    logic [DATA_W-1:0] variance_y;
    logic [DATA_W-1:0] variance_z;
  } in_t;

  typedef struct packed {
    logic              settled;
    logic [DATA_W-1:0] span_x;
    logic [DATA_W-1:0] span_y;
    logic [DATA_W-1:0] span_z;
  } out_t;

  // running extremes handed from cell to cell
  typedef struct packed {
    sample3_t lo;
    sample3_t hi;
  } ext_t;

endpackage

`default_nettype wire

// ===== hdl/vsd_cell.sv =====
// One window cell: holds one entry per axis and folds it into the running extremes.
`timescale 1ns / 1ps
`default_nettype none

module vsd_cell (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic shift,
  input  vsd_pkg::sample3_t  entry_in,
  output vsd_pkg::sample3_t  entry,
  input  vsd_pkg::ext_t      ext_in,
  output vsd_pkg::ext_t      ext_out
);

  vsd_pkg::ext_t ext_next;

  always_comb begin
    for (int a = 0; a < vsd_pkg::AXES; a++) begin
      ext_next.lo[a] = (entry[a] < ext_in.lo[a]) ? entry[a] : ext_in.lo[a];
      ext_next.hi[a] = (entry[a] > ext_in.hi[a]) ? entry[a] : ext_in.hi[a];
    end
  end

  // advance the window on each accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < vsd_pkg::AXES; a++) begin
        entry[a] <= vsd_pkg::INIT_LEVEL;
      end
    end else if (shift) begin
      entry <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    ext_out <= ext_next;
  end

endmodule

`default_nettype wire

// ===== hdl/variance_settle_detector.sv =====
// Top level of the variance settle detector: window cell chain, sweep control, output.
//
//   channel | signals                      | payload
//   --------+------------------------------+---------------------------------
//   in      | in_valid, in_ready, in_data  | vsd_pkg::in_t  (x, y, z variance)
//   out     | out_valid, out_ready, out_data | vsd_pkg::out_t (settled, spans)
//   cfg     | cfg_valid, cfg_ready, cfg_data | span_threshold, 32 bits
//
// The result of a sample is registered at the end of its sweep, and no new sample is
// accepted until that sweep ends: the running min/max moves one cell per cycle down the
// WINDOW-cell chain.
// in_ready is low while a sweep runs; a sweep holds at its end while the
// previous result still waits on out_ready. cfg_ready is always high.
// Synchronous reset loads every window entry with 1000.0 and the threshold with 0.001.
`timescale 1ns / 1ps
`default_nettype none

module variance_settle_detector #(
  parameter int WINDOW = vsd_pkg::WINDOW_DEF
) (
  input  wire  logic          clk,
  input  wire  logic          rst,
  input  wire  logic          in_valid,
  output logic                in_ready,
  input  vsd_pkg::in_t        in_data,
  output logic                out_valid,
  input  wire  logic          out_ready,
  output vsd_pkg::out_t       out_data,
  input  wire  logic          cfg_valid,
  output logic                cfg_ready,
  input  wire  logic [vsd_pkg::DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic                      state;
  logic [CNT_W-1:0]          cnt;
  logic [vsd_pkg::DATA_W-1:0] span_threshold;

  logic in_fire;
  logic capture;

  vsd_pkg::sample3_t entries [WINDOW+1];
  vsd_pkg::ext_t     exts    [WINDOW+1];
  vsd_pkg::sample3_t span;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign capture   = (state == ST_SWEEP) && (cnt == CNT_LAST) && (!out_valid || out_ready);

  assign entries[0] = {in_data.variance_x, in_data.variance_y, in_data.variance_z};

  // seed the chain with neutral extremes
  always_comb begin
    for (int a = 0; a < vsd_pkg::AXES; a++) begin
      exts[0].lo[a] = '1;
      exts[0].hi[a] = '0;
    end
  end

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    vsd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (in_fire),
      .entry_in (entries[k]),
      .entry    (entries[k+1]),
      .ext_in   (exts[k]),
      .ext_out  (exts[k+1])
    );
  end

  always_comb begin
    for (int a = 0; a < vsd_pkg::AXES; a++) begin
      span[a] = exts[WINDOW].hi[a] - exts[WINDOW].lo[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      span_threshold <= vsd_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      span_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_SWEEP;
            cnt   <= '0;
          end
        end
        ST_SWEEP: begin
          if (cnt != CNT_LAST) begin
            cnt <= cnt + 1'b1;
          end else if (capture) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (capture) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      out_data.settled <= (span[2] < span_threshold) && (span[1] < span_threshold)
                          && (span[0] < span_threshold);
      out_data.span_x  <= span[2];
      out_data.span_y  <= span[1];
      out_data.span_z  <= span[0];
    end
  end

endmodule

`default_nettype wire
